[rtl/ttsb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and operation codes for the text terminal screen buffer.
package ttsb_pkg;

	localparam int ROWS    = 24;
	localparam int COLUMNS = 40;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 6;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int PROW_W = $clog2(ROWS);

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_CR   = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_NULL = 8'h00;

	localparam logic [ROW_W:0]  ROWS_X    = (ROW_W + 1)'(ROWS);
	localparam logic [COL_W:0]  COLUMNS_X = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [PROW_W-1:0] LAST_PROW = PROW_W'(ROWS - 1);

endpackage

[rtl/ttsb_ram.sv]
`timescale 1ns / 1ps
// Single-port synchronous RAM with registered read data.
module ttsb_ram #(
	parameter int DEPTH = 960,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

[rtl/text_terminal_screen_buffer_core.sv]
`timescale 1ns / 1ps
// Top level: glass terminal character screen store with cursor and scroll.
// Takes one operation at a time; busy is high from acceptance until the result beat, which
// appears on the result ports for one cycle with done high and cannot be held off. Rows live
// in a ring inside a single-port RAM with a top-row offset and one valid flag per row, so a
// scroll or a clear needs no copying. A row that is not valid reads as zero; the first
// store into such a row first zero-fills it, one cell per cycle. Clears, carriage returns,
// stores into valid rows, out-of-range puts and reads, and reads of unwritten rows finish in
// the execute state; a read of a written row also passes through a read-wait state for the
// registered RAM data; a store into a row that is not valid goes through the fill state first.
module text_terminal_screen_buffer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ttsb_pkg::OP_W-1:0]   operation,
	input  logic [ttsb_pkg::CHAR_W-1:0] char_value,
	input  logic [ttsb_pkg::ROW_W-1:0]  cell_row,
	input  logic [ttsb_pkg::COL_W-1:0]  cell_column,
	output logic                        done,
	output logic [ttsb_pkg::CHAR_W-1:0] cell_out,
	output logic [ttsb_pkg::ROW_W-1:0]  cursor_row_out,
	output logic [ttsb_pkg::COL_W-1:0]  cursor_column_out,
	output logic                        scrolled
);

	import ttsb_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_FILL   = 2'd2;
	localparam logic [1:0] ST_RDWAIT = 2'd3;

	logic [1:0]        state_q;
	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  crow_q;
	logic [COL_W-1:0]  ccol_q;
	logic [PROW_W-1:0] top_q;
	logic [ROWS-1:0]   valid_q;
	logic [COL_W-1:0]  fill_q;
	logic              done_q;
	logic [CHAR_W-1:0] cell_q;
	logic              scr_q;

	logic [ROW_W-1:0]  lrow;
	logic [COL_W-1:0]  lcol;
	logic [PROW_W:0]   psum;
	logic [PROW_W-1:0] phys;
	logic              in_range;
	logic              store;
	logic              wrap;
	logic [COL_W:0]    col_inc;
	logic [COL_W-1:0]  col_idx;
	logic [ADDR_W-1:0] addr;
	logic              we;
	logic [CHAR_W-1:0] wdata;
	logic [CHAR_W-1:0] rdata;
	logic [PROW_W-1:0] top_next;

	always_comb begin
		lrow     = (op_q == OP_WRITE) ? crow_q : row_q;
		lcol     = (op_q == OP_WRITE) ? ccol_q : col_q;
		psum     = {1'b0, PROW_W'(lrow)} + {1'b0, top_q};
		phys     = (psum >= (PROW_W + 1)'(ROWS)) ? PROW_W'(psum - (PROW_W + 1)'(ROWS))
			: PROW_W'(psum);
		in_range = ({1'b0, row_q} < ROWS_X) && ({1'b0, col_q} < COLUMNS_X);
		store    = ((op_q == OP_WRITE) && (ch_q != CHAR_CR)) || ((op_q == OP_PUT) && in_range);
		col_inc  = {1'b0, ccol_q} + (COL_W + 1)'(1);
		wrap     = (ch_q == CHAR_CR) || (col_inc >= COLUMNS_X);
		top_next = (top_q == LAST_PROW) ? '0 : top_q + PROW_W'(1);
		col_idx  = (state_q == ST_FILL) ? fill_q : lcol;
		addr     = ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(col_idx);
		we       = (state_q == ST_FILL) || ((state_q == ST_EXEC) && store && valid_q[phys]);
		wdata    = (state_q == ST_FILL) ? CHAR_NULL : ch_q;
	end

	ttsb_ram #(
		.DEPTH(CELLS),
		.WIDTH(CHAR_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_WRITE;
			ch_q    <= '0;
			row_q   <= '0;
			col_q   <= '0;
			crow_q  <= '0;
			ccol_q  <= '0;
			top_q   <= '0;
			valid_q <= '0;
			fill_q  <= '0;
			done_q  <= 1'b0;
			cell_q  <= '0;
			scr_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= operation;
						ch_q    <= char_value;
						row_q   <= cell_row;
						col_q   <= cell_column;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (op_q)
						OP_CLEAR: begin
							valid_q <= '0;
							top_q   <= '0;
							crow_q  <= '0;
							ccol_q  <= '0;
							cell_q  <= '0;
							scr_q   <= 1'b0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						OP_READ: begin
							if (in_range && valid_q[phys]) begin
								state_q <= ST_RDWAIT;
							end else begin
								cell_q  <= '0;
								scr_q   <= 1'b0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						default: begin
							if (store && !valid_q[phys]) begin
								fill_q  <= '0;
								state_q <= ST_FILL;
							end else begin
								scr_q <= 1'b0;
								if (op_q == OP_WRITE) begin
									if (wrap) begin
										ccol_q <= '0;
										if (crow_q == LAST_ROW) begin
											// old top row becomes the new, empty bottom row
											valid_q[top_q] <= 1'b0;
											top_q          <= top_next;
											scr_q          <= 1'b1;
										end else begin
											crow_q <= crow_q + ROW_W'(1);
										end
									end else begin
										ccol_q <= COL_W'(col_inc);
									end
								end
								cell_q  <= '0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
					endcase
				end
				ST_FILL: begin
					if (fill_q == LAST_COL) begin
						valid_q[phys] <= 1'b1;
						state_q       <= ST_EXEC;
					end else begin
						fill_q <= fill_q + COL_W'(1);
					end
				end
				ST_RDWAIT: begin
					cell_q  <= rdata;
					scr_q   <= 1'b0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign cell_out          = cell_q;
	assign cursor_row_out    = crow_q;
	assign cursor_column_out = ccol_q;
	assign scrolled          = scr_q;

endmodule

[rtl/ttsb_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the screen buffer, bound to the top level.
module ttsb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [ttsb_pkg::ROW_W-1:0]  cursor_row_out,
	input logic [ttsb_pkg::COL_W-1:0]  cursor_column_out,
	input logic                        scrolled
);

	import ttsb_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat lasted more than one cycle");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		done && scrolled |-> (cursor_row_out == LAST_ROW) && (cursor_column_out == '0))
		else $error("scroll left cursor off the bottom row start");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, cursor_row_out} < ROWS_X) && ({1'b0, cursor_column_out} < COLUMNS_X))
		else $error("cursor outside the screen");

endmodule

bind text_terminal_screen_buffer_core ttsb_checker u_ttsb_checker (.*);
